// File: rtl/gtma_pkg.sv
// ============================================================================
// gtma_pkg
// Shared types, codes and defaults for the GEMM tile multiply-accumulate.
// ============================================================================
package gtma_pkg;

    // default geometry
    localparam int TILE_ROWS_DEF = 8;
    localparam int TILE_COLS_DEF = 8;
    localparam int MAX_DEPTH_DEF = 16;

    // fixed field widths
    localparam int ELEM_W  = 16;
    localparam int C_W     = 48;
    localparam int COORD_W = 12;
    localparam int OUT_W   = 13;
    localparam int PROD_W  = 2 * ELEM_W;

    localparam logic signed [C_W-1:0] C_MAX = {1'b0, {(C_W-1){1'b1}}};
    localparam logic signed [C_W-1:0] C_MIN = {1'b1, {(C_W-1){1'b0}}};

    // commands
    localparam logic [1:0] CMD_LOAD_A = 2'd0;
    localparam logic [1:0] CMD_LOAD_B = 2'd1;
    localparam logic [1:0] CMD_LOAD_C = 2'd2;
    localparam logic [1:0] CMD_RUN    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_ROWS  = 2'd1;
    localparam logic [1:0] REG_COLS  = 2'd2;
    localparam logic [1:0] REG_DEPTH = 2'd3;

    // reset values
    localparam logic signed [ELEM_W-1:0] ALPHA_RST = 16'sd256;
    localparam logic [3:0]               ROWS_RST  = 4'd8;
    localparam logic [3:0]               COLS_RST  = 4'd8;
    localparam logic [4:0]               DEPTH_RST = 5'd16;

    typedef struct packed {
        logic [1:0]                command;
        logic [COORD_W-1:0]        row;
        logic [COORD_W-1:0]        col;
        logic signed [ELEM_W-1:0]  element;
        logic signed [C_W-1:0]     partial_sum;
    } t_req;

    typedef struct packed {
        logic [OUT_W-1:0]      out_row;
        logic [OUT_W-1:0]      out_col;
        logic signed [C_W-1:0] value;
        logic                  saturated;
        logic                  last;
    } t_rsp;

    typedef struct packed {
        logic prod_en;
        logic acc_clr;
        logic acc_en;
        logic scale_en;
    } t_mac_ctl;

endpackage

// File: rtl/gtma_ab_mem.sv
// ============================================================================
// gtma_ab_mem
// A block and transposed B block stores, one write and one registered read.
// ============================================================================
module gtma_ab_mem
    import gtma_pkg::*;
#(
    parameter int TILE_ROWS = TILE_ROWS_DEF,
    parameter int TILE_COLS = TILE_COLS_DEF,
    parameter int MAX_DEPTH = MAX_DEPTH_DEF,
    localparam int RW = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1,
    localparam int CW = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1,
    localparam int DW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_we_a,
    input  logic                     i_we_b,
    input  logic [RW-1:0]            i_wr_a_row,
    input  logic [CW-1:0]            i_wr_b_row,
    input  logic [DW-1:0]            i_wr_k,
    input  logic signed [ELEM_W-1:0] i_wr_data,
    input  logic [RW-1:0]            i_rd_a_row,
    input  logic [CW-1:0]            i_rd_b_row,
    input  logic [DW-1:0]            i_rd_k,
    output logic signed [ELEM_W-1:0] o_a,
    output logic signed [ELEM_W-1:0] o_b
);

    logic signed [ELEM_W-1:0] r_mem_a [TILE_ROWS][MAX_DEPTH];
    logic signed [ELEM_W-1:0] r_mem_b [TILE_COLS][MAX_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we_a) begin
            r_mem_a[i_wr_a_row][i_wr_k] <= i_wr_data;
        end
        o_a <= r_mem_a[i_rd_a_row][i_rd_k];
    end

    always_ff @(posedge i_clk) begin
        if (i_we_b) begin
            r_mem_b[i_wr_b_row][i_wr_k] <= i_wr_data;
        end
        o_b <= r_mem_b[i_rd_b_row][i_rd_k];
    end

endmodule

// File: rtl/gtma_c_mem.sv
// ============================================================================
// gtma_c_mem
// C tile store, one write and one registered read per cycle.
// ============================================================================
module gtma_c_mem
    import gtma_pkg::*;
#(
    parameter int TILE_ROWS = TILE_ROWS_DEF,
    parameter int TILE_COLS = TILE_COLS_DEF,
    localparam int RW = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1,
    localparam int CW = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [RW-1:0]         i_wr_row,
    input  logic [CW-1:0]         i_wr_col,
    input  logic signed [C_W-1:0] i_wr_data,
    input  logic [RW-1:0]         i_rd_row,
    input  logic [CW-1:0]         i_rd_col,
    output logic signed [C_W-1:0] o_q
);

    logic signed [C_W-1:0] r_mem [TILE_ROWS][TILE_COLS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_row][i_wr_col] <= i_wr_data;
        end
        o_q <= r_mem[i_rd_row][i_rd_col];
    end

endmodule

// File: rtl/gtma_mac.sv
// ============================================================================
// gtma_mac
// Shared multiply-accumulate, alpha scaling and saturating C update.
// ============================================================================
module gtma_mac
    import gtma_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF,
    localparam int ACC_W = PROD_W + 1 + $clog2(MAX_DEPTH + 1),
    localparam int SCL_W = ACC_W + ELEM_W,
    localparam int SUM_W = ((ACC_W + 8 > C_W) ? ACC_W + 8 : C_W) + 1
) (
    input  logic                     i_clk,
    input  t_mac_ctl                 i_ctl,
    input  logic signed [ELEM_W-1:0] i_a,
    input  logic signed [ELEM_W-1:0] i_b,
    input  logic signed [ELEM_W-1:0] i_alpha,
    input  logic signed [C_W-1:0]    i_c,
    output logic signed [C_W-1:0]    o_value,
    output logic                     o_sat
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [SCL_W-1:0]  r_scaled;
    logic signed [SCL_W-1:0]  w_shift;
    logic signed [SUM_W-1:0]  w_sum;

    always_ff @(posedge i_clk) begin
        if (i_ctl.prod_en) begin
            r_prod <= i_a * i_b;
        end
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_ctl.scale_en) begin
            r_scaled <= r_acc * i_alpha;
        end
    end

    // arithmetic shift = floor division by 256
    assign w_shift = r_scaled >>> 8;
    assign w_sum   = SUM_W'(i_c) + SUM_W'(w_shift);

    always_comb begin
        o_sat   = 1'b0;
        o_value = C_W'(w_sum);
        if (w_sum > SUM_W'(C_MAX)) begin
            o_value = C_MAX;
            o_sat   = 1'b1;
        end else if (w_sum < SUM_W'(C_MIN)) begin
            o_value = C_MIN;
            o_sat   = 1'b1;
        end
    end

endmodule

// File: rtl/gemm_tile_multiply_accumulate.sv
// ============================================================================
// gemm_tile_multiply_accumulate
// Loads (A, B, C) return nothing; busy stays low.
// A run walks every tile entry through one shared MAC.
// Each entry streams depth operand reads, drains the read and product registers, scales, then adds to C.
// A result strobes for one cycle, registered from the add state of its entry.
// Synchronous active-low reset clears control and config; stores undefined.
// ============================================================================
module gemm_tile_multiply_accumulate
    import gtma_pkg::*;
#(
    parameter int TILE_ROWS = TILE_ROWS_DEF,
    parameter int TILE_COLS = TILE_COLS_DEF,
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    // result channel, cannot be stalled
    output logic        o_rsp_valid,
    output t_rsp        o_rsp,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    localparam int RW   = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
    localparam int CW   = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
    localparam int DW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int KC_W = $clog2(MAX_DEPTH + 1);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAC   = 2'd1;   // stream A/B reads through MAC
    localparam logic [1:0] S_SCALE = 2'd2;   // alpha * dot, C read issued
    localparam logic [1:0] S_ADD   = 2'd3;   // C + scaled, write back, emit

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [ELEM_W-1:0] r_alpha;
    logic [3:0]               r_rows;
    logic [3:0]               r_cols;
    logic [4:0]               r_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RST;
            r_rows  <= ROWS_RST;
            r_cols  <= COLS_RST;
            r_depth <= DEPTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ALPHA: r_alpha <= i_cfg_wdata;
                REG_ROWS:  r_rows  <= i_cfg_wdata[3:0];
                REG_COLS:  r_cols  <= i_cfg_wdata[3:0];
                REG_DEPTH: r_depth <= i_cfg_wdata[4:0];
            endcase
        end
    end

    // dimensions above the store size clamp to the store size
    logic [3:0]      w_nr;
    logic [3:0]      w_nc;
    logic [KC_W-1:0] w_nd;

    assign w_nr = (r_rows > 4'(TILE_ROWS)) ? 4'(TILE_ROWS) : r_rows;
    assign w_nc = (r_cols > 4'(TILE_COLS)) ? 4'(TILE_COLS) : r_cols;
    assign w_nd = (int'(r_depth) > MAX_DEPTH) ? KC_W'(MAX_DEPTH) : KC_W'(r_depth);

    // ------------------------------------------------------------------
    // request decode; loads outside the stores are dropped
    // ------------------------------------------------------------------
    logic w_acc;
    logic w_we_a;
    logic w_we_b;
    logic w_ld_c;

    assign w_acc  = start && !busy;
    assign w_we_a = w_acc && (i_req.command == CMD_LOAD_A)
                    && (int'(i_req.row) < TILE_ROWS) && (int'(i_req.col) < MAX_DEPTH);
    assign w_we_b = w_acc && (i_req.command == CMD_LOAD_B)
                    && (int'(i_req.row) < TILE_COLS) && (int'(i_req.col) < MAX_DEPTH);
    assign w_ld_c = w_acc && (i_req.command == CMD_LOAD_C)
                    && (int'(i_req.row) < TILE_ROWS) && (int'(i_req.col) < TILE_COLS);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    logic [1:0]         r_state, n_state;
    logic [RW-1:0]      r_i, n_i;
    logic [CW-1:0]      r_j, n_j;
    logic [KC_W-1:0]    r_k, n_k;
    logic               r_v1, n_v1;       // A/B read data valid
    logic               r_v2, n_v2;       // product valid
    logic [COORD_W-1:0] r_org_row, n_org_row;
    logic [COORD_W-1:0] r_org_col, n_org_col;
    logic               r_rsp_valid, n_rsp_valid;
    t_rsp               r_rsp, n_rsp;

    t_mac_ctl              w_ctl;
    logic                  w_issue;
    logic                  w_last;
    logic                  w_c_we;
    logic signed [C_W-1:0] w_c_q;
    logic signed [C_W-1:0] w_value;
    logic                  w_sat;

    assign busy   = (r_state != S_IDLE);
    assign w_last = (4'(r_i) == w_nr - 4'd1) && (4'(r_j) == w_nc - 4'd1);

    always_comb begin
        n_state       = r_state;
        n_i           = r_i;
        n_j           = r_j;
        n_k           = r_k;
        n_org_row     = r_org_row;
        n_org_col     = r_org_col;
        n_rsp_valid   = 1'b0;
        n_rsp         = r_rsp;
        w_issue       = 1'b0;
        w_c_we        = 1'b0;
        w_ctl.prod_en  = r_v1;
        w_ctl.acc_en   = r_v2;
        w_ctl.acc_clr  = 1'b0;
        w_ctl.scale_en = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                // empty tile: run ends at once with no results
                if (w_acc && (i_req.command == CMD_RUN)
                    && (w_nr != 4'd0) && (w_nc != 4'd0)) begin
                    n_state       = S_MAC;
                    n_i           = '0;
                    n_j           = '0;
                    n_k           = '0;
                    n_org_row     = i_req.row;
                    n_org_col     = i_req.col;
                    w_ctl.acc_clr = 1'b1;
                end
            end
            S_MAC: begin
                if (r_k != w_nd) begin
                    w_issue = 1'b1;
                    n_k     = r_k + KC_W'(1);
                end else if (!r_v1 && !r_v2) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                w_ctl.scale_en = 1'b1;
                n_state        = S_ADD;
            end
            S_ADD: begin
                w_c_we              = 1'b1;
                n_rsp_valid         = 1'b1;
                n_rsp.out_row       = OUT_W'(r_org_row) + OUT_W'(r_i);
                n_rsp.out_col       = OUT_W'(r_org_col) + OUT_W'(r_j);
                n_rsp.value         = w_value;
                n_rsp.saturated     = w_sat;
                n_rsp.last          = w_last;
                if (w_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_state       = S_MAC;
                    n_k           = '0;
                    w_ctl.acc_clr = 1'b1;
                    if (4'(r_j) == w_nc - 4'd1) begin
                        n_j = '0;
                        n_i = r_i + RW'(1);
                    end else begin
                        n_j = r_j + CW'(1);
                    end
                end
            end
        endcase
    end

    assign n_v1 = w_issue;
    assign n_v2 = r_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_org_row <= n_org_row;
        r_org_col <= n_org_col;
        r_rsp     <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // ------------------------------------------------------------------
    // stores and datapath
    // ------------------------------------------------------------------
    logic signed [ELEM_W-1:0] w_a;
    logic signed [ELEM_W-1:0] w_b;

    gtma_ab_mem #(
        .TILE_ROWS (TILE_ROWS),
        .TILE_COLS (TILE_COLS),
        .MAX_DEPTH (MAX_DEPTH)
    ) u_ab_mem (
        .i_clk      (i_clk),
        .i_we_a     (w_we_a),
        .i_we_b     (w_we_b),
        .i_wr_a_row (i_req.row[RW-1:0]),
        .i_wr_b_row (i_req.row[CW-1:0]),
        .i_wr_k     (i_req.col[DW-1:0]),
        .i_wr_data  (i_req.element),
        .i_rd_a_row (r_i),
        .i_rd_b_row (r_j),
        .i_rd_k     (r_k[DW-1:0]),
        .o_a        (w_a),
        .o_b        (w_b)
    );

    // loads only happen while idle, run write-back only in S_ADD
    logic [RW-1:0]         w_c_wr_row;
    logic [CW-1:0]         w_c_wr_col;
    logic signed [C_W-1:0] w_c_wr_data;

    assign w_c_wr_row  = w_c_we ? r_i : i_req.row[RW-1:0];
    assign w_c_wr_col  = w_c_we ? r_j : i_req.col[CW-1:0];
    assign w_c_wr_data = w_c_we ? w_value : i_req.partial_sum;

    gtma_c_mem #(
        .TILE_ROWS (TILE_ROWS),
        .TILE_COLS (TILE_COLS)
    ) u_c_mem (
        .i_clk     (i_clk),
        .i_we      (w_c_we || w_ld_c),
        .i_wr_row  (w_c_wr_row),
        .i_wr_col  (w_c_wr_col),
        .i_wr_data (w_c_wr_data),
        .i_rd_row  (r_i),
        .i_rd_col  (r_j),
        .o_q       (w_c_q)
    );

    gtma_mac #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_mac (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_alpha (r_alpha),
        .i_c     (w_c_q),
        .o_value (w_value),
        .o_sat   (w_sat)
    );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GEMM tile multiply-accumulate testbench
// Loads A/B/C stores, fires tile runs under several register settings and
// checks every emitted tile entry against an in-bench tile predictor.
// ----------------------------------------------------------------------------
module testbench;
    import gtma_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and DUT hookup
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        start = 1'b0;
    logic        busy;
    t_req        req = '0;
    logic        rsp_valid;
    t_rsp        rsp;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    gemm_tile_multiply_accumulate u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .o_rsp       (rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run (every request a full
    // 8x8x16 tile run plus sender gaps).
    initial begin
        #(30_000_000);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_req request_q[$];        // requests waiting for the driver
    t_rsp expected_entries[$]; // tile entries the predictor expects next
    int   idle_pct = 8;        // chance (percent) the sender holds off
    int   err_count = 0;
    logic req_accepted;        // start && !busy seen at the last rising edge

    // Predictor copy of the stores and registers
    logic signed [ELEM_W-1:0] a_mem [TILE_ROWS_DEF][MAX_DEPTH_DEF];
    logic signed [ELEM_W-1:0] b_mem [TILE_COLS_DEF][MAX_DEPTH_DEF];
    logic signed [C_W-1:0]    c_mem [TILE_ROWS_DEF][TILE_COLS_DEF];
    logic signed [ELEM_W-1:0] alpha_r = ALPHA_RST;
    logic [3:0]               rows_r  = ROWS_RST;
    logic [3:0]               cols_r  = COLS_RST;
    logic [4:0]               depth_r = DEPTH_RST;

    task automatic note_error(input string what);
        err_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Loads outside the store are dropped by the block; runs always count.
    function automatic bit reaches_store(input t_req r);
        case (r.command)
            CMD_LOAD_A: return r.row < TILE_ROWS_DEF && r.col < MAX_DEPTH_DEF;
            CMD_LOAD_B: return r.row < TILE_COLS_DEF && r.col < MAX_DEPTH_DEF;
            CMD_LOAD_C: return r.row < TILE_ROWS_DEF && r.col < TILE_COLS_DEF;
            default:    return 1'b1;
        endcase
    endfunction

    // Tile predictor: applies one accepted request, queues the tile entries
    // a run produces (row-major, last flag on the final entry).
    task automatic update_tile(input t_req r);
        int     nr, nc, nd;
        longint dot, acc;
        bit     sat;
        t_rsp   e;
        if (r.command != CMD_RUN) begin
            if (reaches_store(r)) begin
                case (r.command)
                    CMD_LOAD_A: a_mem[r.row][r.col] = r.element;
                    CMD_LOAD_B: b_mem[r.row][r.col] = r.element;
                    default:    c_mem[r.row][r.col] = r.partial_sum;
                endcase
            end
        end else begin
            // oversized dimensions clamp to the tile geometry
            nr = (rows_r  > TILE_ROWS_DEF) ? TILE_ROWS_DEF : int'(rows_r);
            nc = (cols_r  > TILE_COLS_DEF) ? TILE_COLS_DEF : int'(cols_r);
            nd = (depth_r > MAX_DEPTH_DEF) ? MAX_DEPTH_DEF : int'(depth_r);
            for (int i = 0; i < nr; i++) begin
                for (int j = 0; j < nc; j++) begin
                    dot = 0;
                    for (int k = 0; k < nd; k++)
                        dot += longint'(a_mem[i][k]) * longint'(b_mem[j][k]);
                    // Q.24 -> Q.16 with floor, then 48-bit saturating add
                    acc = longint'(c_mem[i][j]) + ((longint'(alpha_r) * dot) >>> 8);
                    sat = 1'b0;
                    if (acc > longint'(C_MAX)) begin
                        acc = longint'(C_MAX);
                        sat = 1'b1;
                    end
                    if (acc < longint'(C_MIN)) begin
                        acc = longint'(C_MIN);
                        sat = 1'b1;
                    end
                    c_mem[i][j] = acc[C_W-1:0];
                    e.out_row   = 13'(r.row + i);
                    e.out_col   = 13'(r.col + j);
                    e.value     = acc[C_W-1:0];
                    e.saturated = sat;
                    e.last      = (i == nr - 1) && (j == nc - 1);
                    expected_entries.push_back(e);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: presents requests at the falling edge, holds start until
    // the request is taken, and inserts random gaps between requests.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        logic drive_now;
        drive_now = start;
        if (start && req_accepted)
            drive_now = 1'b0;
        if (!drive_now && request_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            req <= request_q.pop_front();
            drive_now = 1'b1;
        end
        start <= drive_now; // single update per step keeps back-to-back start high
    end

    // ------------------------------------------------------------------
    // Monitor: checks strobed tile entries, then feeds accepted requests
    // to the predictor. Results can't be stalled, so every strobe counts.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_rsp want;
        if (!rst_n) begin
            req_accepted <= 1'b0;
        end else begin
            if (rsp_valid) begin
                if (expected_entries.size() == 0) begin
                    note_error($sformatf("unexpected tile entry row %0d col %0d",
                                         rsp.out_row, rsp.out_col));
                end else begin
                    want = expected_entries.pop_front();
                    if (rsp.out_row !== want.out_row)
                        note_error($sformatf("out_row %0d, want %0d",
                                             rsp.out_row, want.out_row));
                    if (rsp.out_col !== want.out_col)
                        note_error($sformatf("out_col %0d, want %0d",
                                             rsp.out_col, want.out_col));
                    if (rsp.value !== want.value)
                        note_error($sformatf("value %0d at (%0d,%0d), want %0d",
                                             rsp.value, want.out_row, want.out_col,
                                             want.value));
                    if (rsp.saturated !== want.saturated)
                        note_error($sformatf("saturated %b at (%0d,%0d), want %b",
                                             rsp.saturated, want.out_row,
                                             want.out_col, want.saturated));
                    if (rsp.last !== want.last)
                        note_error($sformatf("last %b at (%0d,%0d), want %b",
                                             rsp.last, want.out_row, want.out_col,
                                             want.last));
                end
            end
            if (start && !busy)
                update_tile(req);
            req_accepted <= start && !busy;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_req mk_req(input logic [1:0] cmd, input logic [11:0] row,
                                    input logic [11:0] col,
                                    input logic signed [15:0] elem,
                                    input logic signed [47:0] psum);
        t_req r;
        r.command     = cmd;
        r.row         = row;
        r.col         = col;
        r.element     = elem;
        r.partial_sum = psum;
        return r;
    endfunction

    // C values: mostly anywhere, sometimes hugging either rail so that
    // accumulation clips.
    function automatic logic signed [47:0] rand_psum();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       return C_MAX - 48'($urandom_range(0, 1 << 20));
            1:       return C_MIN + 48'($urandom_range(0, 1 << 20));
            default: return w[47:0];
        endcase
    endfunction

    // Register writes only happen with the block idle; the predictor copy
    // follows immediately since nothing is in flight.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_ALPHA: alpha_r = data;
            REG_ROWS:  rows_r  = data[3:0];
            REG_COLS:  cols_r  = data[3:0];
            default:   depth_r = data[4:0];
        endcase
        @(negedge clk);
    endtask

    // Upper data bits on the dimension registers are junk the block must drop.
    task automatic set_config(input logic [15:0] alpha, input logic [3:0] rows,
                              input logic [3:0] cols, input logic [4:0] depth);
        write_reg(REG_ALPHA, alpha);
        write_reg(REG_ROWS,  {12'($urandom), rows});
        write_reg(REG_COLS,  {12'($urandom), cols});
        write_reg(REG_DEPTH, {11'($urandom), depth});
        cfg_we <= 1'b0;
    endtask

    // Wait for every request to be taken and every entry to come out, then
    // let the pipeline settle before touching registers.
    task automatic drain_and_pause();
        int waited;
        waited = 0;
        while (request_q.size() != 0 || start)
            @(posedge clk);
        while ((expected_entries.size() != 0 || busy) && waited < 4000) begin
            @(posedge clk);
            waited++;
        end
        repeat (32) @(negedge clk);
        if (expected_entries.size() != 0) begin
            note_error($sformatf("%0d tile entries never came out",
                                 expected_entries.size()));
            expected_entries.delete();
        end
    endtask

    // Every store entry gets written before any run can read it.
    task automatic fill_stores();
        for (int i = 0; i < TILE_ROWS_DEF; i++)
            for (int k = 0; k < MAX_DEPTH_DEF; k++)
                request_q.push_back(mk_req(CMD_LOAD_A, 12'(i), 12'(k), 16'($urandom),
                                           rand_psum()));
        for (int j = 0; j < TILE_COLS_DEF; j++)
            for (int k = 0; k < MAX_DEPTH_DEF; k++)
                request_q.push_back(mk_req(CMD_LOAD_B, 12'(j), 12'(k), 16'($urandom),
                                           rand_psum()));
        for (int i = 0; i < TILE_ROWS_DEF; i++)
            for (int j = 0; j < TILE_COLS_DEF; j++)
                request_q.push_back(mk_req(CMD_LOAD_C, 12'(i), 12'(j), 16'($urandom),
                                           rand_psum()));
    endtask

    // Random traffic: mostly loads aimed inside the active tile followed by
    // runs, with some loads scattered anywhere (most of those get dropped).
    // Only requests that touch the block count toward the total.
    task automatic add_traffic(input int count);
        int   made, pick, nr, nc, nd;
        t_req r;
        made = 0;
        nr = (rows_r == 0 || rows_r > TILE_ROWS_DEF) ? TILE_ROWS_DEF : int'(rows_r);
        nc = (cols_r == 0 || cols_r > TILE_COLS_DEF) ? TILE_COLS_DEF : int'(cols_r);
        nd = (depth_r == 0 || depth_r > MAX_DEPTH_DEF) ? MAX_DEPTH_DEF : int'(depth_r);
        while (made < count) begin
            pick = $urandom_range(0, 99);
            r = mk_req(2'($urandom_range(CMD_LOAD_A, CMD_LOAD_C)),
                       12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                       16'($urandom), rand_psum());
            if (pick < 10) begin
                r.command = CMD_RUN;
            end else if (pick < 88) begin
                case (r.command)
                    CMD_LOAD_A: begin
                        r.row = 12'($urandom_range(0, nr - 1));
                        r.col = 12'($urandom_range(0, nd - 1));
                    end
                    CMD_LOAD_B: begin
                        r.row = 12'($urandom_range(0, nc - 1));
                        r.col = 12'($urandom_range(0, nd - 1));
                    end
                    default: begin
                        r.row = 12'($urandom_range(0, nr - 1));
                        r.col = 12'($urandom_range(0, nc - 1));
                    end
                endcase
            end
            request_q.push_back(r);
            if (reaches_store(r))
                made++;
        end
    endtask

    task automatic run_phase(input logic [15:0] alpha, input logic [3:0] rows,
                             input logic [3:0] cols, input logic [4:0] depth,
                             input int count);
        set_config(alpha, rows, cols, depth);
        add_traffic(count);
        drain_and_pause();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_ALPHA;
        cfg_wdata = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Fill everything, then one run on the reset register values.
        fill_stores();
        request_q.push_back(mk_req(CMD_RUN, 0, 0, 16'($urandom), rand_psum()));
        drain_and_pause();

        // Directed: depth 1 so only column 0 of A and B matters.
        set_config(16'sh7fff, 4'd8, 4'd8, 5'd1);
        // (0,0): min * min is the largest product, on top of C at the top
        // rail -> clips high
        request_q.push_back(mk_req(CMD_LOAD_A, 0, 0, 16'sh8000, rand_psum()));
        request_q.push_back(mk_req(CMD_LOAD_B, 0, 0, 16'sh8000, rand_psum()));
        request_q.push_back(mk_req(CMD_LOAD_C, 0, 0, 16'($urandom), C_MAX));
        // (1,1): max * min, on top of C at the bottom rail -> clips low
        request_q.push_back(mk_req(CMD_LOAD_A, 1, 0, 16'sh7fff, rand_psum()));
        request_q.push_back(mk_req(CMD_LOAD_B, 1, 0, 16'sh8000, rand_psum()));
        request_q.push_back(mk_req(CMD_LOAD_C, 1, 1, 16'($urandom), C_MIN));
        // (2,2): tiny negative product, floor rounding of the scaled sum
        request_q.push_back(mk_req(CMD_LOAD_A, 2, 0, 16'sh0001, rand_psum()));
        request_q.push_back(mk_req(CMD_LOAD_B, 2, 0, 16'shffff, rand_psum()));
        // highest store indexes
        request_q.push_back(mk_req(CMD_LOAD_A, 7, 15, 16'sh7fff, rand_psum()));
        request_q.push_back(mk_req(CMD_LOAD_B, 7, 15, 16'shffff, rand_psum()));
        request_q.push_back(mk_req(CMD_LOAD_C, 7, 7, 16'($urandom), 48'hffff_ffff_ffff));
        // loads just past, and far past, each store: dropped
        request_q.push_back(mk_req(CMD_LOAD_A, 8, 0, 16'($urandom), rand_psum()));
        request_q.push_back(mk_req(CMD_LOAD_A, 0, 16, 16'($urandom), rand_psum()));
        request_q.push_back(mk_req(CMD_LOAD_B, 8, 3, 16'($urandom), rand_psum()));
        request_q.push_back(mk_req(CMD_LOAD_B, 4095, 4095, 16'($urandom), rand_psum()));
        request_q.push_back(mk_req(CMD_LOAD_C, 0, 8, 16'($urandom), rand_psum()));
        request_q.push_back(mk_req(CMD_LOAD_C, 8, 0, 16'($urandom), rand_psum()));
        // lowest and highest tile origins; second run re-accumulates
        request_q.push_back(mk_req(CMD_RUN, 0, 0, 16'($urandom), rand_psum()));
        request_q.push_back(mk_req(CMD_RUN, 4095, 4095, 16'($urandom), rand_psum()));
        drain_and_pause();

        // Random phases: light sender gaps, then heavy, then none.
        idle_pct = 8;
        run_phase(16'sh8000, 4'd1, 4'd1, 5'd1, 12);            // smallest tile
        run_phase(16'($urandom), 4'd15, 4'd15, 5'd31, 12);     // clamped to max
        idle_pct = 72;
        run_phase(16'($urandom), 4'd5, 4'd3, 5'd0, 10);        // empty dot product
        run_phase(16'($urandom), 4'd0, 4'd8, 5'd7, 6);         // zero rows: silent
        run_phase(16'($urandom), 4'd8, 4'd0, 5'd9, 4);         // zero cols: silent
        idle_pct = 0;
        run_phase(16'($urandom), 4'($urandom_range(1, 8)), 4'($urandom_range(1, 8)),
                  5'($urandom_range(1, 16)), 18);
        run_phase(ALPHA_RST, ROWS_RST, COLS_RST, DEPTH_RST, 18);

        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
